[rtl/tsa_pkg.sv]
// ----------------------------------------------------------------------------
// Tagged slot allocator package
// Shared sizes, the command word passed from the front end to the scan engine,
// and its kind codes.
// ----------------------------------------------------------------------------
package tsa_pkg;

  localparam int NUM_SLOTS   = 128;
  localparam int TAG_BITS    = 16;
  localparam int VALUE_W     = 16;
  localparam int FREE_W      = 8;
  localparam int IDX_W       = $clog2(NUM_SLOTS);
  localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_RESERVE,
    CMD_CANCEL,
    CMD_DONE_OK,
    CMD_DONE_FAIL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [CNT_W-1:0]     need;
    logic [TAG_BITS-1:0]  tag;
  } cmd_t;

endpackage

[rtl/tsa_front.sv]
// ----------------------------------------------------------------------------
// Tagged slot allocator front end
// Accepts request words, rounds the reserve count, masks the tags and decides
// the requests that need no scan of the slot row and no look at the free count.
// ----------------------------------------------------------------------------
module tsa_front (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         opcode,
  input  logic [tsa_pkg::VALUE_W-1:0]  request_value,
  input  logic [tsa_pkg::VALUE_W-1:0]  owner_tag,
  input  logic                         q_full,
  output logic                         q_push,
  output tsa_pkg::cmd_t                q_cmd
);

  logic [tsa_pkg::VALUE_W:0]    need_wide;
  logic [tsa_pkg::TAG_BITS-1:0] res_tag;
  logic [tsa_pkg::TAG_BITS-1:0] can_tag;

  assign need_wide = ({1'b0, request_value} + (tsa_pkg::VALUE_W + 1)'(1))
                     & ~(tsa_pkg::VALUE_W + 1)'(1);
  assign res_tag   = tsa_pkg::TAG_BITS'(owner_tag);
  assign can_tag   = tsa_pkg::TAG_BITS'(request_value);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.need = tsa_pkg::CNT_W'(need_wide);
    if (opcode) begin
      q_cmd.tag  = can_tag;
      q_cmd.kind = (can_tag == '0) ? tsa_pkg::CMD_DONE_OK : tsa_pkg::CMD_CANCEL;
    end else begin
      q_cmd.tag = res_tag;
      if (res_tag == '0) begin
        q_cmd.kind = tsa_pkg::CMD_DONE_FAIL;
      end else if (need_wide == '0) begin
        q_cmd.kind = tsa_pkg::CMD_DONE_OK;
      end else if (need_wide > (tsa_pkg::VALUE_W + 1)'(tsa_pkg::NUM_SLOTS)) begin
        q_cmd.kind = tsa_pkg::CMD_DONE_FAIL;
      end else begin
        q_cmd.kind = tsa_pkg::CMD_RESERVE;
      end
    end
  end

endmodule

[rtl/tsa_queue.sv]
// ----------------------------------------------------------------------------
// Tagged slot allocator command queue
// A short FIFO of classified commands between the front end and the scan
// engine.
// ----------------------------------------------------------------------------
module tsa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tsa_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output tsa_pkg::cmd_t  head
);

  tsa_pkg::cmd_t               entries [tsa_pkg::QUEUE_DEPTH];
  logic [tsa_pkg::QPTR_W-1:0]  wr_ptr;
  logic [tsa_pkg::QPTR_W-1:0]  rd_ptr;
  logic [tsa_pkg::QCNT_W-1:0]  count;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (count == tsa_pkg::QCNT_W'(tsa_pkg::QUEUE_DEPTH));
  assign avail   = (count != '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  function automatic logic [tsa_pkg::QPTR_W-1:0] bump(
    input logic [tsa_pkg::QPTR_W-1:0] p
  );
    if (p == tsa_pkg::QPTR_W'(tsa_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + tsa_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + tsa_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - tsa_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

[rtl/tsa_back.sv]
// ----------------------------------------------------------------------------
// Tagged slot allocator scan engine
// Holds the slot row and the free count, carries out reserve and cancel
// commands with one slot per cycle, and holds the result word.
// ----------------------------------------------------------------------------
module tsa_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_avail,
  input  tsa_pkg::cmd_t               q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        ok,
  output logic [tsa_pkg::FREE_W-1:0]  free_slots
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } state_t;

  state_t                        state;
  tsa_pkg::cmd_t                 cmd;
  logic                          ok_pend;
  logic [tsa_pkg::CNT_W-1:0]     free_total;
  logic [tsa_pkg::CNT_W-1:0]     placed;
  logic [tsa_pkg::IDX_W-1:0]     addr;

  logic [tsa_pkg::TAG_BITS-1:0]  mem [tsa_pkg::NUM_SLOTS];
  logic [tsa_pkg::NUM_SLOTS-1:0] slot_valid;
  logic [tsa_pkg::TAG_BITS-1:0]  mem_q;
  logic                          valid_q;
  logic                          rd_valid_d;
  logic [tsa_pkg::IDX_W-1:0]     rd_idx_d;

  logic [tsa_pkg::TAG_BITS-1:0]  slot_val;
  logic                          wr_en;
  logic [tsa_pkg::TAG_BITS-1:0]  wr_data;
  logic                          take_slot;
  logic                          drop_slot;
  logic                          out_free;

  assign slot_val  = valid_q ? mem_q : '0;
  assign take_slot = rd_valid_d && (cmd.kind == tsa_pkg::CMD_RESERVE)
                     && (slot_val == '0) && (placed != cmd.need);
  assign drop_slot = rd_valid_d && (cmd.kind == tsa_pkg::CMD_CANCEL)
                     && (slot_val == cmd.tag);
  assign wr_en     = take_slot || drop_slot;
  assign wr_data   = take_slot ? cmd.tag : '0;
  assign q_pop     = (state == ST_IDLE) && q_avail;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    mem_q <= mem[addr];
    if (wr_en) begin
      mem[rd_idx_d] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      valid_q    <= 1'b0;
    end else begin
      valid_q <= slot_valid[addr];
      if (wr_en) begin
        slot_valid[rd_idx_d] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      free_total <= tsa_pkg::CNT_W'(tsa_pkg::NUM_SLOTS);
      placed     <= '0;
      addr       <= '0;
      rd_valid_d <= 1'b0;
      ok_pend    <= 1'b0;
    end else begin
      rd_valid_d <= (state == ST_SCAN);
      rd_idx_d   <= addr;
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      if (take_slot) begin
        placed     <= placed + tsa_pkg::CNT_W'(1);
        free_total <= free_total - tsa_pkg::CNT_W'(1);
      end else if (drop_slot) begin
        free_total <= free_total + tsa_pkg::CNT_W'(1);
      end
      case (state)
        ST_IDLE: begin
          addr   <= '0;
          placed <= '0;
          if (q_avail) begin
            cmd <= q_head;
            case (q_head.kind)
              tsa_pkg::CMD_RESERVE: begin
                if (q_head.need > free_total) begin
                  ok_pend <= 1'b0;
                  state   <= ST_DONE;
                end else begin
                  ok_pend <= 1'b1;
                  state   <= ST_SCAN;
                end
              end
              tsa_pkg::CMD_CANCEL: begin
                ok_pend <= 1'b1;
                state   <= ST_SCAN;
              end
              tsa_pkg::CMD_DONE_OK: begin
                ok_pend <= 1'b1;
                state   <= ST_DONE;
              end
              default: begin
                ok_pend <= 1'b0;
                state   <= ST_DONE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (addr == tsa_pkg::IDX_W'(tsa_pkg::NUM_SLOTS - 1)) begin
            state <= ST_FLUSH;
          end else begin
            addr <= addr + tsa_pkg::IDX_W'(1);
          end
        end
        ST_FLUSH: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            ok         <= ok_pend;
            free_slots <= tsa_pkg::FREE_W'(free_total);
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= tsa_pkg::CNT_W'(tsa_pkg::NUM_SLOTS))
    else $error("free count exceeds the slot row");

  a_placed_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.kind == tsa_pkg::CMD_RESERVE && state != ST_IDLE) |-> placed <= cmd.need)
    else $error("reserve placed more slots than requested");

  a_reserve_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && cmd.kind == tsa_pkg::CMD_RESERVE && ok_pend)
    |-> placed == cmd.need)
    else $error("granted reserve did not place every slot");

  a_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_SCAN || state == ST_FLUSH))
    else $error("slot write outside a scan");

endmodule

[rtl/tagged_slot_allocator_core.sv]
// ----------------------------------------------------------------------------
// Tagged slot allocator core
// Reserves and cancels runs of owner-tagged slots and reports the free count.
// ----------------------------------------------------------------------------
// A scanned request passes the queue register and the scan engine's IDLE, SCAN,
// FLUSH and DONE states before its result word is registered; a request that
// is decided without a scan skips SCAN and FLUSH. The scan reads the slot memory
// one slot per cycle, and the engine pops no new command until it leaves DONE.
// Reset: all slots free at once through per-slot valid bits, with no clearing
// pass; words are accepted in the first cycle after reset.
module tagged_slot_allocator_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         opcode,
  input  logic [tsa_pkg::VALUE_W-1:0]  request_value,
  input  logic [tsa_pkg::VALUE_W-1:0]  owner_tag,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         ok,
  output logic [tsa_pkg::FREE_W-1:0]   free_slots
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_avail;
  tsa_pkg::cmd_t q_cmd;
  tsa_pkg::cmd_t q_head;

  tsa_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .request_value (request_value),
    .owner_tag     (owner_tag),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  tsa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  tsa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_avail    (q_avail),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ok         (ok),
    .free_slots (free_slots)
  );

endmodule
